### rtl/core/fvn_pkg.sv
//------------------------------------------------------------------------------
// fvn_pkg
// Shared constants for the fractal value noise pipeline.
//------------------------------------------------------------------------------
package fvn_pkg;

	localparam int unsigned MaxOctavesDef = 8;
	localparam int unsigned FracBitsDef   = 16;

	localparam logic [31:0] HashMulX = 32'd374761393;
	localparam logic [31:0] HashMulY = 32'd668265263;
	localparam logic [31:0] HashMulM = 32'd1274126177;
	localparam logic [31:0] SeedStep = 32'd1000;

	// configuration register indexes
	localparam logic [0:0] RegSeed   = 1'b0;
	localparam logic [0:0] RegOctave = 1'b1;

	localparam logic [3:0] OctaveReset = 4'd5;

endpackage

### rtl/core/fractal_value_noise.sv
//------------------------------------------------------------------------------
// fractal_value_noise
// Fractal 2-D value noise, smoothstep blend, signed Q16.16 in, Q0.16 out.
//
//  channel  | handshake        | payload
//  ---------+------------------+----------------------------------
//  command  | start / busy     | coord_x, coord_y
//  result   | done (strobe)    | noise_value
//  config   | cfg_valid/ready  | cfg_index, cfg_data
//
// One item per cycle; busy is tied low. Registers lie in the octave units
// (hash and blend multipliers), after the octave sum, and in the normalizer
// (reciprocal multiply and correction).
// Reset clears the valid line and the registers (seed 0, five octaves).
// The receiver cannot stall; done pulses once per item.
//------------------------------------------------------------------------------
module fractal_value_noise import fvn_pkg::*; #(
	parameter int unsigned MAX_OCTAVES = MaxOctavesDef,
	parameter int unsigned FRAC_BITS   = FracBitsDef
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [31:0] coord_x,
	input  logic [31:0] coord_y,
	output logic        done,
	output logic [15:0] noise_value,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [0:0]  cfg_index,
	input  logic [31:0] cfg_data
);

	localparam int unsigned Lat = 11;
	localparam int unsigned SW  = MAX_OCTAVES + 31;

	logic [31:0] seed_q;
	logic [3:0]  oct_q;
	logic [4:0]  octs;
	logic [Lat-1:0] vld_q;

	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_q <= '0;
			oct_q  <= OctaveReset;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				RegSeed:   seed_q <= cfg_data;
				RegOctave: oct_q  <= cfg_data[3:0];
				default: ;
			endcase
		end
	end

	// clamp octave count to 1..MAX_OCTAVES
	always_comb begin
		if (oct_q == 4'd0) octs = 5'd1;
		else if (32'(oct_q) > MAX_OCTAVES) octs = 5'(MAX_OCTAVES);
		else octs = 5'(oct_q);
	end

	// valid line
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_q <= '0;
		else vld_q <= {vld_q[Lat-2:0], start};
	end

	// octave units
	logic [30:0] val [MAX_OCTAVES];
	genvar g;
	generate
		for (g = 0; g < MAX_OCTAVES; g++) begin : g_oct
			fvn_octave #(.FRAC_BITS(FRAC_BITS), .SHIFT(g)) u_oct (
				.clk     (clk),
				.seed    (seed_q + SeedStep * 32'(g)),
				.coord_x (coord_x),
				.coord_y (coord_y),
				.value   (val[g])
			);
		end
	endgenerate

	// stage 8: weighted octave sum
	logic [SW-1:0] sum_s8;
	logic [SW-1:0] acc;
	always_comb begin
		acc = '0;
		for (int k = 0; k < MAX_OCTAVES; k++)
			if (5'(k) < octs)
				acc = acc + (SW'(val[k]) << (MAX_OCTAVES - 1 - k));
	end
	always_ff @(posedge clk) sum_s8 <= acc;

	fvn_norm #(.MAX_OCTAVES(MAX_OCTAVES)) u_norm (
		.clk  (clk),
		.sum  (sum_s8),
		.octs (octs),
		.quot (noise_value)
	);

	assign done = vld_q[Lat-1];

endmodule

### rtl/core/fvn_octave.sv
//------------------------------------------------------------------------------
// fvn_octave
// One octave: lattice hash of four corners, smoothstep weights, bilinear blend.
// Seven register stages; one item per cycle.
//------------------------------------------------------------------------------
module fvn_octave import fvn_pkg::*; #(
	parameter int unsigned FRAC_BITS = FracBitsDef,
	parameter int unsigned SHIFT     = 0
) (
	input  logic        clk,
	input  logic [31:0] seed,
	input  logic [31:0] coord_x,
	input  logic [31:0] coord_y,
	output logic [30:0] value
);

	localparam int unsigned F = FRAC_BITS;
	localparam int unsigned W = 32 + F;

	logic [W-1:0] sx, sy;
	logic [31:0]  ix, iy;
	logic [F-1:0] fx, fy;

	// scale point (sign extended past the index bits), split index and fraction
	assign sx = W'(signed'(coord_x)) << SHIFT;
	assign sy = W'(signed'(coord_y)) << SHIFT;
	assign ix = sx[W-1:F];
	assign iy = sy[W-1:F];
	assign fx = sx[F-1:0];
	assign fy = sy[F-1:0];

	// stage 1: corner products, fraction squares
	logic [31:0]  mx0_s1, mx1_s1, my0_s1, my1_s1, seed_s1;
	logic [F-1:0] fx_s1, fy_s1;
	logic [2*F-1:0] tx2_s1, ty2_s1;
	always_ff @(posedge clk) begin
		mx0_s1  <= ix * HashMulX;
		mx1_s1  <= (ix + 32'd1) * HashMulX;
		my0_s1  <= iy * HashMulY;
		my1_s1  <= (iy + 32'd1) * HashMulY;
		seed_s1 <= seed;
		fx_s1   <= fx;
		fy_s1   <= fy;
		tx2_s1  <= fx * fx;
		ty2_s1  <= fy * fy;
	end

	// stage 2: xor mix, hash multiply; smoothstep product
	function automatic logic [31:0] pre_mix(input logic [31:0] a);
		return a ^ (a >> 13);
	endfunction
	logic [31:0] hm_s2 [4];
	logic [F+1:0] kx, ky;
	logic [F-1:0] tx, ty;
	logic [2*F+1:0] swx_s2, swy_s2;
	assign tx = tx2_s1[2*F-1:F];
	assign ty = ty2_s1[2*F-1:F];
	assign kx = (F+2)'(3) << F;
	assign ky = kx;
	always_ff @(posedge clk) begin
		hm_s2[0] <= pre_mix(seed_s1 ^ mx0_s1 ^ my0_s1) * HashMulM;
		hm_s2[1] <= pre_mix(seed_s1 ^ mx1_s1 ^ my0_s1) * HashMulM;
		hm_s2[2] <= pre_mix(seed_s1 ^ mx0_s1 ^ my1_s1) * HashMulM;
		hm_s2[3] <= pre_mix(seed_s1 ^ mx1_s1 ^ my1_s1) * HashMulM;
		swx_s2   <= (2*F+2)'(tx) * (2*F+2)'(kx - {1'b0, fx_s1, 1'b0});
		swy_s2   <= (2*F+2)'(ty) * (2*F+2)'(ky - {1'b0, fy_s1, 1'b0});
	end

	// stage 3: final hash fold, weights
	logic [30:0]  c_s3 [4];
	logic [F-1:0] wx_s3, wy_s3;
	always_ff @(posedge clk) begin
		for (int k = 0; k < 4; k++)
			c_s3[k] <= 31'(hm_s2[k] ^ (hm_s2[k] >> 16));
		wx_s3 <= swx_s2[2*F-1:F];
		wy_s3 <= swy_s2[2*F-1:F];
	end

	// stage 4: x blend products
	logic [31+F:0] pa_s4, pb_s4, pc_s4, pd_s4;
	logic [F-1:0]  wy_s4;
	always_ff @(posedge clk) begin
		pa_s4 <= c_s3[0] * ((F+1)'(1) << F) - c_s3[0] * wx_s3;
		pb_s4 <= c_s3[1] * wx_s3;
		pc_s4 <= c_s3[2] * ((F+1)'(1) << F) - c_s3[2] * wx_s3;
		pd_s4 <= c_s3[3] * wx_s3;
		wy_s4 <= wy_s3;
	end

	// stage 5: x blend sum
	logic [30:0]  ab_s5, cd_s5;
	logic [F-1:0] wy_s5;
	logic [32+F:0] sab, scd;
	assign sab = (33+F)'(pa_s4) + (33+F)'(pb_s4);
	assign scd = (33+F)'(pc_s4) + (33+F)'(pd_s4);
	always_ff @(posedge clk) begin
		ab_s5 <= 31'(sab >> F);
		cd_s5 <= 31'(scd >> F);
		wy_s5 <= wy_s4;
	end

	// stage 6: y blend products
	logic [31+F:0] pe_s6, pf_s6;
	always_ff @(posedge clk) begin
		pe_s6 <= ab_s5 * ((F+1)'(1) << F) - ab_s5 * wy_s5;
		pf_s6 <= cd_s5 * wy_s5;
	end

	// stage 7: y blend sum
	logic [32+F:0] sef;
	assign sef = (33+F)'(pe_s6) + (33+F)'(pf_s6);
	always_ff @(posedge clk) begin
		value <= 31'(sef >> F);
	end

endmodule

### rtl/core/fvn_norm.sv
//------------------------------------------------------------------------------
// fvn_norm
// Normalizes the weighted octave sum by the total weight: multiply by a
// scaled reciprocal, then one correction step. Three register stages.
//------------------------------------------------------------------------------
module fvn_norm import fvn_pkg::*; #(
	parameter int unsigned MAX_OCTAVES = MaxOctavesDef
) (
	input  logic                    clk,
	input  logic [MAX_OCTAVES+30:0] sum,
	input  logic [4:0]              octs,
	output logic [15:0]             quot
);

	localparam int unsigned SW = MAX_OCTAVES + 31;
	localparam int unsigned RB = 40;

	// divisor D = W * 2^15, W = 2^M - 2^(M-n); q = floor(sum/D) fits 16 bits
	function automatic logic [MAX_OCTAVES:0] total_w(input logic [4:0] n);
		return ((MAX_OCTAVES+1)'(1) << MAX_OCTAVES) -
			((MAX_OCTAVES+1)'(1) << (MAX_OCTAVES - int'(n)));
	endfunction

	// reciprocal of W scaled by 2^RB (rounded up), one constant per octave count
	logic [RB:0] rtab [MAX_OCTAVES+1];
	logic [RB:0] r_sel;
	assign rtab[0] = '0;
	for (genvar gn = 1; gn <= MAX_OCTAVES; gn++) begin : g_recip
		localparam logic [RB+MAX_OCTAVES:0] Wn =
			(RB+MAX_OCTAVES+1)'(total_w(5'(gn)));
		localparam logic [RB:0] RecipN =
			(RB+1)'((((RB+MAX_OCTAVES+1)'(1) << RB) + Wn - 1) / Wn);
		assign rtab[gn] = RecipN;
	end

	always_comb begin
		r_sel = rtab[0];
		for (int k = 1; k <= MAX_OCTAVES; k++)
			if (octs == 5'(k)) r_sel = rtab[k];
	end

	// stage 1: s = sum >> 15, reciprocal lookup
	logic [SW-16:0]      s_s1;
	logic [RB:0]         r_s1;
	logic [MAX_OCTAVES:0] w_s1;
	always_ff @(posedge clk) begin
		s_s1 <= sum[SW-1:15];
		r_s1 <= r_sel;
		w_s1 <= total_w(octs);
	end

	// stage 2: estimate quotient
	logic [SW-15+RB:0] prod;
	logic [17:0]       qe_s2;
	logic [SW-16:0]    s_s2;
	logic [MAX_OCTAVES:0] w_s2;
	assign prod = (SW-14+RB)'(s_s1) * (SW-14+RB)'(r_s1);
	always_ff @(posedge clk) begin
		qe_s2 <= 18'(prod >> RB);
		s_s2  <= s_s1;
		w_s2  <= w_s1;
	end

	// stage 3: correct overshoot by one, saturate
	logic [SW+9:0] qw;
	logic [17:0]   qc;
	assign qw = (SW+10)'(qe_s2) * (SW+10)'(w_s2);
	assign qc = (qw > (SW+10)'(s_s2)) ? qe_s2 - 18'd1 : qe_s2;
	always_ff @(posedge clk) begin
		quot <= (qc > 18'd65535) ? 16'hFFFF : qc[15:0];
	end

endmodule

### test/tb_top.sv
`timescale 1ns / 1ps
//------------------------------------------------------------------------------
// tb_top
// Checks the fractal value noise block: directed corner points, then random
// points under several seed and octave settings, each result compared with
// a behavioral noise predictor kept in this bench.
//------------------------------------------------------------------------------
module tb_top import fvn_pkg::*; ();

	localparam int unsigned NumOct = 8;
	localparam int unsigned FracW  = 16;
	localparam int unsigned Latency = 11;
	localparam longint unsigned CycleLimit = 400000;

	typedef struct {
		logic [31:0] x;
		logic [31:0] y;
		bit          known;
		logic [15:0] value;
	} point_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic        busy;
	logic [31:0] coord_x = '0;
	logic [31:0] coord_y = '0;
	logic        done;
	logic [15:0] noise_value;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [0:0]  cfg_index = RegSeed;
	logic [31:0] cfg_data = '0;

	// predictor copy of the registers
	logic [31:0] seed_q = '0;
	logic [3:0]  octaves_q = OctaveReset;

	logic [15:0] noise_pending[$];
	int unsigned fails = 0;
	longint unsigned cycles = 0;

	fractal_value_noise i_dut (.*);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// run-time limit
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CycleLimit) begin
			$display("[fractal_value_noise] ERROR");
			$finish;
		end
	end

	function automatic logic [31:0] corner_hash(logic [31:0] ix, logic [31:0] iy,
			logic [31:0] s);
		logic [31:0] h;
		h = s ^ (ix * HashMulX);
		h = h ^ (iy * HashMulY);
		h = (h ^ (h >> 13)) * HashMulM;
		h = h ^ (h >> 16);
		return {1'b0, h[30:0]};
	endfunction

	function automatic logic [63:0] fade(logic [63:0] f);
		logic [63:0] t;
		t = (f * f) >> FracW;
		return (t * ((64'd3 << FracW) - 2 * f)) >> FracW;
	endfunction

	function automatic logic [63:0] mix(logic [63:0] a, logic [63:0] b, logic [63:0] s);
		return (a * ((64'd1 << FracW) - s) + b * s) >> FracW;
	endfunction

	function automatic logic [15:0] predict_noise(logic [31:0] x, logic [31:0] y);
		logic [63:0] px, py, sx, sy, wx, wy, sum, total, q;
		logic [31:0] ix, iy, s;
		int n;
		px = {{32{x[31]}}, x};
		py = {{32{y[31]}}, y};
		n = (octaves_q == 0) ? 1 : (octaves_q > NumOct) ? NumOct : octaves_q;
		sum = 0;
		for (int i = 0; i < n; i++) begin
			s = seed_q + SeedStep * i;
			sx = px << i;
			sy = py << i;
			ix = sx[47:16];
			iy = sy[47:16];
			wx = fade({48'd0, sx[15:0]});
			wy = fade({48'd0, sy[15:0]});
			sum += mix(mix(corner_hash(ix, iy, s), corner_hash(ix + 1, iy, s), wx),
				mix(corner_hash(ix, iy + 1, s), corner_hash(ix + 1, iy + 1, s), wx),
				wy) << (NumOct - 1 - i);
		end
		total = (64'd1 << NumOct) - (64'd1 << (NumOct - n));
		q = sum / (total << 15);
		return (q > 65535) ? 16'hFFFF : q[15:0];
	endfunction

	// result check at every strobe
	always @(posedge clk) begin
		if (arst_n && done) begin
			if (noise_pending.size() == 0) begin
				$error("noise_value: unexpected item, actual %0d", noise_value);
				fails++;
			end else begin
				logic [15:0] want;
				want = noise_pending.pop_front();
				if (noise_value !== want) begin
					$error("noise_value: expected %0d, actual %0d", want, noise_value);
					fails++;
				end
			end
		end
	end

	task automatic write_reg(logic [0:0] idx, logic [31:0] data);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
		if (idx == RegSeed) seed_q = data;
		else octaves_q = data[3:0];
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// one item; gaps optional
	task automatic send_point(point_t p, bit gaps);
		@(negedge clk);
		while (gaps && $urandom_range(99) < 15) begin
			start <= 1'b0;
			@(negedge clk);
		end
		start   <= 1'b1;
		coord_x <= p.x;
		coord_y <= p.y;
		do @(posedge clk); while (busy);
		noise_pending.push_back(p.known ? p.value : predict_noise(p.x, p.y));
	endtask

	task automatic drain();
		@(negedge clk);
		start <= 1'b0;
		while (noise_pending.size() != 0) @(posedge clk);
		repeat (Latency + 4) @(posedge clk);
	endtask

	function automatic logic [31:0] rand_coord();
		case ($urandom_range(3))
			0: return $urandom();
			1: return {{12{1'($urandom_range(1))}}, 20'($urandom())};
			2: return {$urandom_range(1) ? 16'hFFFF : 16'h0000, 16'($urandom())};
			default: return {16'($urandom()), 16'(16'hFFFF - $urandom_range(3))};
		endcase
	endfunction

	point_t corner_rows[] = '{
		'{32'h0000_0000, 32'h0000_0000, 1'b0, 16'd0},
		'{32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0, 16'd0},
		'{32'h8000_0000, 32'h8000_0000, 1'b0, 16'd0},
		'{32'h7FFF_FFFF, 32'h8000_0000, 1'b0, 16'd0},
		'{32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, 16'd0},
		'{32'h0000_FFFF, 32'h0000_8000, 1'b0, 16'd0},
		'{32'hFFFF_0000, 32'h0001_0000, 1'b0, 16'd0},
		'{32'h5555_5555, 32'hAAAA_AAAA, 1'b0, 16'd0},
		'{32'hAAAA_AAAA, 32'h5555_5555, 1'b0, 16'd0},
		'{32'h0000_0001, 32'hFFFF_FFFE, 1'b0, 16'd0}
	};

	logic [31:0] seed_set[] = '{32'h0, 32'hFFFF_FFFF, 32'hFFFF_FC18, 32'h1234_5678};
	logic [3:0]  oct_set[]  = '{4'd1, 4'd8, 4'd0, 4'd15, 4'd3, 4'd5};

	initial begin
		point_t p;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed rows at reset settings, then with extreme settings
		foreach (corner_rows[r]) send_point(corner_rows[r], 1'b0);
		drain();
		write_reg(RegSeed, 32'hFFFF_FFFF);
		write_reg(RegOctave, 32'd8);
		foreach (corner_rows[r]) send_point(corner_rows[r], 1'b1);
		drain();

		// random phases across settings
		for (int ph = 0; ph < 6; ph++) begin
			write_reg(RegSeed, ph < 4 ? seed_set[ph] : $urandom());
			write_reg(RegOctave, 32'(oct_set[ph]));
			for (int k = 0; k < 80; k++) begin
				p.x = rand_coord();
				p.y = rand_coord();
				p.known = 1'b0;
				p.value = '0;
				send_point(p, ph != 2);
				if (ph == 4 && k == 40) drain();
			end
			drain();
		end

		if (fails == 0)
			$display("[fractal_value_noise] OK");
		else
			$display("[fractal_value_noise] ERROR");
		$finish;
	end

endmodule
